>>> hw/rtl/lbeg_pkg.sv
// ============================================================================
// lbeg_pkg: shared constants, types and tables of the LED breathing generator
// Fixed-point formats, register and mode codes, the 2^-x fraction table and
// the handshake struct of the bit-serial arithmetic units.
// ============================================================================
package lbeg_pkg;

  // Fixed-point and table sizes
  localparam int FRAC_BITS       = 16;
  localparam int DAC_BITS        = 10;
  localparam int EXP_TABLE_DEPTH = 256;

  localparam int FULL_SCALE = 100;
  localparam int HYST_LOW   = 10;
  localparam int PERIOD_DIV = 15000;             // ms*speed_tenths per half-life
  localparam int PWM_DIV    = FULL_SCALE * FULL_SCALE;

  // Field widths
  localparam int MS_W   = 16;
  localparam int SPD_W  = 7;
  localparam int MAX_W  = 7;
  localparam int MODE_W = 3;
  localparam int PCT_W  = 7;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;

  // Derived widths
  localparam int LVL_W     = PCT_W + FRAC_BITS;        // Q7.FRAC level
  localparam int FW        = FRAC_BITS + 1;            // decay factor, 1.0 included
  localparam int IDX_W     = $clog2(EXP_TABLE_DEPTH);
  localparam int P_W       = MS_W + SPD_W;             // elapsed * speed
  localparam int TDIV_W    = P_W + IDX_W;              // quotient: n then table index
  localparam int N_W       = P_W;
  localparam int SH_W      = $clog2(FW);
  localparam int X_W       = LVL_W + MAX_W;            // level * max_level
  localparam int Y_W       = X_W + DAC_BITS;           // times 2^DAC - 1
  localparam int PWM_NUM_W = Y_W - FRAC_BITS;

  localparam int IN_DATA_W  = ((MS_W + 7) / 8) * 8;
  localparam int OUT_FLD_W  = 2 * DAC_BITS + 2 * PCT_W;
  localparam int OUT_DATA_W = ((OUT_FLD_W + 7) / 8) * 8;

  localparam logic [LVL_W-1:0] LVL_FULL = LVL_W'(FULL_SCALE << FRAC_BITS);
  localparam logic [LVL_W-1:0] LVL_HI   = LVL_W'((FULL_SCALE - HYST_LOW) << FRAC_BITS);
  localparam logic [LVL_W-1:0] LVL_LO   = LVL_W'(HYST_LOW << FRAC_BITS);
  localparam logic [DAC_BITS-1:0] DMAX  = '1;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MAX_LEVEL   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_EFFECT_MODE = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_SPEED       = CFG_IDX_W'(2);

  // Effect modes; other codes leave the levels alone
  localparam logic [MODE_W-1:0] MODE_STATIC  = MODE_W'(0);
  localparam logic [MODE_W-1:0] MODE_BREATH  = MODE_W'(1);
  localparam logic [MODE_W-1:0] MODE_OPPOSED = MODE_W'(2);

  // Control of a serial unit: load operands, then one step per cycle
  typedef struct packed {
    logic load;
    logic step;
  } ser_ctl_t;

  // 2^-(i/DEPTH) in Q1.FRAC, rounded, from a 12-term series of exp(-x ln2) in Q30
  localparam int         EXP_TAB_W = EXP_TABLE_DEPTH * FW;
  localparam logic [63:0] Q30_ONE  = 64'd1 << 30;
  localparam logic [63:0] LN2_Q30  = 64'd744261118;

  function automatic logic [EXP_TAB_W-1:0] build_exp_tab();
    logic [EXP_TAB_W-1:0] tab;
    logic [63:0]          x;
    logic [63:0]          y;
    logic [63:0]          term;
    logic [63:0]          sum;
    logic [63:0]          ent;
    tab = '0;
    for (int i = 0; i < EXP_TABLE_DEPTH; i++) begin
      x    = (64'(i) << 30) >> IDX_W;
      y    = (x * LN2_Q30) >> 30;
      term = Q30_ONE;
      sum  = Q30_ONE;
      for (int k = 1; k <= 12; k++) begin
        term = ((term * y) >> 30) / 64'(k);
        if (k[0]) begin
          sum = sum - term;
        end else begin
          sum = sum + term;
        end
      end
      ent = (sum + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
      tab[i*FW +: FW] = ent[FW-1:0];
    end
    return tab;
  endfunction

  localparam logic [EXP_TAB_W-1:0] EXP_TAB = build_exp_tab();

  function automatic logic [FW-1:0] exp_lookup(input logic [IDX_W-1:0] idx);
    return EXP_TAB[FW*idx +: FW];
  endfunction

endpackage

>>> hw/rtl/led_breathing_effect_generator_core.sv
// ============================================================================
// led_breathing_effect_generator_core: two-channel LED breathing PWM engine
// Each request is a timer tick carrying elapsed milliseconds. The left level
// decays exponentially toward 0 or 100 percent; the right level mirrors or
// opposes it. Both levels are scaled by max_level to DAC_BITS-wide PWM codes.
// ============================================================================
//
//  channel  dir  handshake                   payload
//  -------  ---  --------------------------  ---------------------------------
//  s_axis   in   s_axis_tvalid_i/tready_o    elapsed_ms
//  m_axis   out  m_axis_tvalid_o/tready_i    left_pwm, right_pwm, left/right %
//  cfg      in   cfg_we_i (no wait)          cfg_idx_i, cfg_data_i
//
//  Work per request: modes 1/2 run the elapsed*speed multiply, the bit-serial
//  divider pass for the time split and the serial multiply of level by
//  factor before the PWM scaling passes; other modes run only the latter.
//  Reset: levels and target cleared, max_level 0, mode 0, speed_tenths 10.
//  Stalls: the result sits in an output register; the engine idles in its
//  final state only while that register is still full and not taken.
//
module led_breathing_effect_generator_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // slave side: [15:0] elapsed_ms
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  input  logic [lbeg_pkg::IN_DATA_W-1:0]    s_axis_tdata_i,
  // master side: [9:0] left_pwm, [19:10] right_pwm, [26:20] left_percent,
  //              [33:27] right_percent, [39:34] zero
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  output logic [lbeg_pkg::OUT_DATA_W-1:0]   m_axis_tdata_o,
  // configuration write port
  input  logic                              cfg_we_i,
  input  logic [lbeg_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [lbeg_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import lbeg_pkg::*;

  // Longest serial pass sets the step counter width
  localparam int CNT_MAX = (TDIV_W > PWM_NUM_W) ? TDIV_W : PWM_NUM_W;
  localparam int CNT_W   = $clog2(CNT_MAX + 1);
  localparam int PAD_W   = OUT_DATA_W - OUT_FLD_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL_P,    // elapsed * speed
    S_DIV_T,    // split into whole half-lives and table index
    S_MUL_L,    // level (or distance to full) times decay factor
    S_UPDATE,   // write levels, hysteresis on target
    S_MUL_M,    // both levels times max_level
    S_DIV_PWM,  // divide by 100*100 for the PWM code
    S_DONE
  } state_e;

  state_e             state_q, state_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;

  // configuration
  logic [MAX_W-1:0]   max_q, max_d;
  logic [MODE_W-1:0]  mode_q, mode_d;
  logic [SPD_W-1:0]   speed_q, speed_d;

  // effect state
  logic [LVL_W-1:0]   left_level_q, left_level_d;
  logic [LVL_W-1:0]   right_level_q, right_level_d;
  logic               target_q, target_d;

  // output register
  logic               m_valid_q, m_valid_d;
  logic [DAC_BITS-1:0] lpwm_q, lpwm_d;
  logic [DAC_BITS-1:0] rpwm_q, rpwm_d;
  logic [PCT_W-1:0]   lpct_q, lpct_d;
  logic [PCT_W-1:0]   rpct_q, rpct_d;

  logic               s_accept;
  ser_ctl_t           ctl_p, ctl_t, ctl_l, ctl_m, ctl_d;

  // datapath
  logic [P_W-1:0]       p_prod;
  logic [TDIV_W-1:0]    t_quo;
  logic [N_W-1:0]       n_half;
  logic [IDX_W-1:0]     t_idx;
  logic [FW-1:0]        tab_val;
  logic [FW-1:0]        factor;
  logic [LVL_W-1:0]     lv_clamp;
  logic [LVL_W-1:0]     l_opnd;
  logic [LVL_W+FW-1:0]  l_prod;
  logic [LVL_W-1:0]     l_scaled;
  logic [LVL_W-1:0]     lv_new;
  logic [X_W-1:0]       xl, xr;
  logic [Y_W-1:0]       yl, yr;
  logic [PWM_NUM_W-1:0] ql, qr;
  logic [DAC_BITS-1:0]  lpwm_sat, rpwm_sat;

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign s_accept        = s_axis_tvalid_i && s_axis_tready_o;

  // --------------------------------------------------------------------------
  // Serial unit sequencing: each unit but u_mul_p loads in the first cycle of
  // its state (counter at its step count), then steps down to zero.
  // --------------------------------------------------------------------------
  always_comb begin
    ctl_p.load = s_accept;
    ctl_p.step = (state_q == S_MUL_P);
    ctl_t.load = (state_q == S_DIV_T) && (cnt_q == CNT_W'(TDIV_W));
    ctl_t.step = (state_q == S_DIV_T) && !ctl_t.load;
    ctl_l.load = (state_q == S_MUL_L) && (cnt_q == CNT_W'(FW));
    ctl_l.step = (state_q == S_MUL_L) && !ctl_l.load;
    ctl_m.load = (state_q == S_MUL_M) && (cnt_q == CNT_W'(MAX_W));
    ctl_m.step = (state_q == S_MUL_M) && !ctl_m.load;
    ctl_d.load = (state_q == S_DIV_PWM) && (cnt_q == CNT_W'(PWM_NUM_W));
    ctl_d.step = (state_q == S_DIV_PWM) && !ctl_d.load;
  end

  // p = elapsed_ms * speed_tenths
  lbeg_smul #(
    .A_W (MS_W),
    .B_W (SPD_W)
  ) u_mul_p (
    .clk_i  (clk_i),
    .ctl_i  (ctl_p),
    .a_i    (s_axis_tdata_i[MS_W-1:0]),
    .b_i    (speed_q),
    .prod_o (p_prod)
  );

  // (p << IDX_W) / 15000: upper bits are whole half-lives, low IDX_W bits the
  // fraction index r*DEPTH/15000, since the long division just runs on.
  lbeg_cdiv #(
    .NUM_W   (TDIV_W),
    .DIVISOR (PERIOD_DIV)
  ) u_div_t (
    .clk_i (clk_i),
    .ctl_i (ctl_t),
    .num_i ({p_prod, IDX_W'(0)}),
    .quo_o (t_quo)
  );

  assign n_half  = t_quo[TDIV_W-1:IDX_W];
  assign t_idx   = t_quo[IDX_W-1:0];
  assign tab_val = exp_lookup(t_idx);
  // Table entries are below 2^FW, so any shift of FW or more gives zero
  assign factor  = (n_half >= N_W'(FW)) ? '0 : (tab_val >> n_half[SH_W-1:0]);

  assign lv_clamp = (left_level_q > LVL_FULL) ? LVL_FULL : left_level_q;
  // Toward full the decay works on the distance to full
  assign l_opnd   = target_q ? (LVL_FULL - lv_clamp) : lv_clamp;

  lbeg_smul #(
    .A_W (LVL_W),
    .B_W (FW)
  ) u_mul_l (
    .clk_i  (clk_i),
    .ctl_i  (ctl_l),
    .a_i    (l_opnd),
    .b_i    (factor),
    .prod_o (l_prod)
  );

  assign l_scaled = l_prod[FRAC_BITS +: LVL_W];
  assign lv_new   = target_q ? (LVL_FULL - l_scaled) : l_scaled;

  // PWM scaling, both channels side by side
  lbeg_smul #(
    .A_W (LVL_W),
    .B_W (MAX_W)
  ) u_mul_lm (
    .clk_i  (clk_i),
    .ctl_i  (ctl_m),
    .a_i    (left_level_q),
    .b_i    (max_q),
    .prod_o (xl)
  );

  lbeg_smul #(
    .A_W (LVL_W),
    .B_W (MAX_W)
  ) u_mul_rm (
    .clk_i  (clk_i),
    .ctl_i  (ctl_m),
    .a_i    (right_level_q),
    .b_i    (max_q),
    .prod_o (xr)
  );

  // x * (2^DAC - 1), then drop the fraction bits before the divide by 10000
  assign yl = {xl, DAC_BITS'(0)} - {DAC_BITS'(0), xl};
  assign yr = {xr, DAC_BITS'(0)} - {DAC_BITS'(0), xr};

  lbeg_cdiv #(
    .NUM_W   (PWM_NUM_W),
    .DIVISOR (PWM_DIV)
  ) u_div_l (
    .clk_i (clk_i),
    .ctl_i (ctl_d),
    .num_i (yl[Y_W-1:FRAC_BITS]),
    .quo_o (ql)
  );

  lbeg_cdiv #(
    .NUM_W   (PWM_NUM_W),
    .DIVISOR (PWM_DIV)
  ) u_div_r (
    .clk_i (clk_i),
    .ctl_i (ctl_d),
    .num_i (yr[Y_W-1:FRAC_BITS]),
    .quo_o (qr)
  );

  // max_level above 100 can push the code past full scale
  assign lpwm_sat = (ql > PWM_NUM_W'(DMAX)) ? DMAX : ql[DAC_BITS-1:0];
  assign rpwm_sat = (qr > PWM_NUM_W'(DMAX)) ? DMAX : qr[DAC_BITS-1:0];

  // --------------------------------------------------------------------------
  // Sequencer, effect state and configuration
  // --------------------------------------------------------------------------
  always_comb begin
    state_d       = state_q;
    cnt_d         = cnt_q;
    max_d         = max_q;
    mode_d        = mode_q;
    speed_d       = speed_q;
    left_level_d  = left_level_q;
    right_level_d = right_level_q;
    target_d      = target_q;
    m_valid_d     = m_valid_q;
    lpwm_d        = lpwm_q;
    rpwm_d        = rpwm_q;
    lpct_d        = lpct_q;
    rpct_d        = rpct_q;

    if (m_valid_q && m_axis_tready_i) begin
      m_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (s_accept) begin
          case (mode_q) inside
            MODE_STATIC: begin
              left_level_d  = LVL_FULL;
              right_level_d = LVL_FULL;
              state_d       = S_MUL_M;
              cnt_d         = CNT_W'(MAX_W);
            end
            MODE_BREATH, MODE_OPPOSED: begin
              state_d = S_MUL_P;
              cnt_d   = CNT_W'(SPD_W - 1);
            end
            default: begin
              // unimplemented modes: levels untouched
              state_d = S_MUL_M;
              cnt_d   = CNT_W'(MAX_W);
            end
          endcase
        end
      end
      S_MUL_P: begin
        if (cnt_q == '0) begin
          state_d = S_DIV_T;
          cnt_d   = CNT_W'(TDIV_W);
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      S_DIV_T: begin
        if (cnt_q == '0) begin
          state_d = S_MUL_L;
          cnt_d   = CNT_W'(FW);
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      S_MUL_L: begin
        if (cnt_q == '0) begin
          state_d = S_UPDATE;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      S_UPDATE: begin
        left_level_d  = lv_new;
        right_level_d = (mode_q == MODE_BREATH) ? lv_new : (LVL_FULL - lv_new);
        if (lv_new >= LVL_HI) begin
          target_d = 1'b0;
        end
        if (lv_new <= LVL_LO) begin
          target_d = 1'b1;
        end
        state_d = S_MUL_M;
        cnt_d   = CNT_W'(MAX_W);
      end
      S_MUL_M: begin
        if (cnt_q == '0) begin
          state_d = S_DIV_PWM;
          cnt_d   = CNT_W'(PWM_NUM_W);
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      S_DIV_PWM: begin
        if (cnt_q == '0) begin
          state_d = S_DONE;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      S_DONE: begin
        if (!m_valid_q || m_axis_tready_i) begin
          m_valid_d = 1'b1;
          lpwm_d    = lpwm_sat;
          rpwm_d    = rpwm_sat;
          lpct_d    = left_level_q[FRAC_BITS +: PCT_W];
          rpct_d    = right_level_q[FRAC_BITS +: PCT_W];
          state_d   = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // Register writes; a mode write clears both levels, target kept
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_MAX_LEVEL: begin
          max_d = cfg_data_i[MAX_W-1:0];
        end
        REG_EFFECT_MODE: begin
          mode_d        = cfg_data_i[MODE_W-1:0];
          left_level_d  = '0;
          right_level_d = '0;
        end
        REG_SPEED: begin
          speed_d = cfg_data_i[SPD_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      cnt_q         <= '0;
      max_q         <= '0;
      mode_q        <= MODE_STATIC;
      speed_q       <= SPD_W'(10);
      left_level_q  <= '0;
      right_level_q <= '0;
      target_q      <= 1'b0;
      m_valid_q     <= 1'b0;
      lpwm_q        <= '0;
      rpwm_q        <= '0;
      lpct_q        <= '0;
      rpct_q        <= '0;
    end else begin
      state_q       <= state_d;
      cnt_q         <= cnt_d;
      max_q         <= max_d;
      mode_q        <= mode_d;
      speed_q       <= speed_d;
      left_level_q  <= left_level_d;
      right_level_q <= right_level_d;
      target_q      <= target_d;
      m_valid_q     <= m_valid_d;
      lpwm_q        <= lpwm_d;
      rpwm_q        <= rpwm_d;
      lpct_q        <= lpct_d;
      rpct_q        <= rpct_d;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {PAD_W'(0), rpct_q, lpct_q, rpwm_q, lpwm_q};

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  ap_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_accept |=> !s_axis_tready_o)
    else $error("engine took a second request while busy");

  ap_level_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (left_level_q <= LVL_FULL) && (right_level_q <= LVL_FULL))
    else $error("level above full scale");

  ap_mirror: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_DONE) && (mode_q == MODE_BREATH)) |-> (right_level_q == left_level_q))
    else $error("right level does not mirror left in breathing mode");

  ap_hysteresis: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_DONE) && ((mode_q == MODE_BREATH) || (mode_q == MODE_OPPOSED)) &&
     (left_level_q >= LVL_HI)) |-> !target_q)
    else $error("target still high above the upper threshold");

endmodule

>>> hw/rtl/lbeg_smul.sv
// ============================================================================
// lbeg_smul: bit-serial shift-add multiplier
// One multiplier bit per step, LSB first; product is valid after B_W steps.
// ============================================================================
module lbeg_smul #(
  parameter int A_W = 16,
  parameter int B_W = 7
) (
  input  logic                    clk_i,
  input  lbeg_pkg::ser_ctl_t      ctl_i,
  input  logic [A_W-1:0]          a_i,
  input  logic [B_W-1:0]          b_i,
  output logic [A_W+B_W-1:0]      prod_o
);
  import lbeg_pkg::*;

  logic [A_W-1:0]     a_q, a_d;
  logic [B_W-1:0]     b_q, b_d;
  logic [A_W+B_W-1:0] acc_q, acc_d;
  logic [A_W:0]       sum;

  always_comb begin
    sum   = {1'b0, acc_q[A_W+B_W-1:B_W]} + (b_q[0] ? {1'b0, a_q} : '0);
    a_d   = a_q;
    b_d   = b_q;
    acc_d = acc_q;
    if (ctl_i.load) begin
      a_d   = a_i;
      b_d   = b_i;
      acc_d = '0;
    end else if (ctl_i.step) begin
      b_d   = b_q >> 1;
      acc_d = {sum, acc_q[B_W-1:1]};
    end
  end

  always_ff @(posedge clk_i) begin
    a_q   <= a_d;
    b_q   <= b_d;
    acc_q <= acc_d;
  end

  assign prod_o = acc_q;

endmodule

>>> hw/rtl/lbeg_cdiv.sv
// ============================================================================
// lbeg_cdiv: bit-serial restoring divider by a constant
// Numerator enters MSB first, one quotient bit per step; done after NUM_W steps.
// ============================================================================
module lbeg_cdiv #(
  parameter int NUM_W   = 31,
  parameter int DIVISOR = 15000
) (
  input  logic                clk_i,
  input  lbeg_pkg::ser_ctl_t  ctl_i,
  input  logic [NUM_W-1:0]    num_i,
  output logic [NUM_W-1:0]    quo_o
);
  import lbeg_pkg::*;

  localparam int REM_W = $clog2(DIVISOR);
  localparam logic [REM_W:0] DIV_K = (REM_W+1)'(DIVISOR);

  logic [NUM_W-1:0] num_q, num_d;
  logic [NUM_W-1:0] quo_q, quo_d;
  logic [REM_W-1:0] rem_q, rem_d;
  logic [REM_W:0]   trial;
  logic [REM_W:0]   diff;
  logic             ge;

  always_comb begin
    trial = {rem_q, num_q[NUM_W-1]};
    ge    = (trial >= DIV_K);
    diff  = trial - DIV_K;
    num_d = num_q;
    quo_d = quo_q;
    rem_d = rem_q;
    if (ctl_i.load) begin
      num_d = num_i;
      rem_d = '0;
    end else if (ctl_i.step) begin
      num_d = num_q << 1;
      quo_d = {quo_q[NUM_W-2:0], ge};
      rem_d = ge ? diff[REM_W-1:0] : trial[REM_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    quo_q <= quo_d;
    rem_q <= rem_d;
  end

  assign quo_o = quo_q;

endmodule

>>> sim/tb_led_breathing_effect_generator_core.sv
// ============================================================================
// tb_led_breathing_effect_generator_core: self-checking bench of the breathing core
// Drives timer ticks into the slave stream and predicts each result with a
// local copy of the level, target and register state. Results are checked
// field by field in order. A directed opening covers the corner cases; random
// phases follow, with random idling on both streams and output back-pressure.
// ============================================================================
module tb_led_breathing_effect_generator_core;
  import lbeg_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;   // cycles with no handshake at all
  localparam int HOLD_CYCLES    = 600;     // long output stall, fills the core
  localparam int DRAIN_CYCLES   = 100;     // settle time at the very end

  // index past the last register: the core must ignore writes to it
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = CFG_IDX_W'(3);
  // highest mode code; everything above MODE_OPPOSED is unimplemented
  localparam logic [MODE_W-1:0]    MODE_LAST  = '1;

  // one result, packed as on m_axis_tdata (left_pwm in the low bits)
  typedef struct packed {
    logic [PCT_W-1:0]    right_pct;
    logic [PCT_W-1:0]    left_pct;
    logic [DAC_BITS-1:0] right_pwm;
    logic [DAC_BITS-1:0] left_pwm;
  } lamp_out_t;

  logic                  clk_i           = 1'b0;
  logic                  rst_ni          = 1'b0;
  logic                  s_axis_tvalid_i = 1'b0;
  logic                  s_axis_tready_o;
  logic [IN_DATA_W-1:0]  s_axis_tdata_i  = '0;   // [15:0] elapsed_ms
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata_o;         // [9:0] left_pwm, [19:10] right_pwm,
                                                 // [26:20] left_percent,
                                                 // [33:27] right_percent
  logic                  cfg_we_i        = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i       = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i      = '0;

  led_breathing_effect_generator_core u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Predictor state: registers, levels and breathing target
  // --------------------------------------------------------------------------
  logic [FW-1:0]      decay_tab [EXP_TABLE_DEPTH];  // 2^-(i/DEPTH), Q1.FRAC
  logic [MAX_W-1:0]   cfg_max;
  logic [MODE_W-1:0]  cfg_mode;
  logic [SPD_W-1:0]   cfg_speed;
  logic [LVL_W-1:0]   lvl_left;
  logic [LVL_W-1:0]   lvl_right;
  logic               aim_high;                    // breathing toward 100 percent

  logic [MS_W-1:0]    tick_queue [$];              // requests not yet offered
  lamp_out_t          lamp_expect_q [$];           // predicted results in order
  bit                 steady;                      // no random idling while set
  int                 err_count;
  int                 shown_count;
  int                 results_seen;
  int                 hold_left;
  int                 idle_cycles;

  // Series for exp(-x ln2) in Q30, 12 terms, rounded to FRAC_BITS.
  task automatic fill_decay_tab();
    logic [63:0] x;
    logic [63:0] y;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] ent;
    for (int i = 0; i < EXP_TABLE_DEPTH; i++) begin
      x    = (64'(i) << 30) / 64'(EXP_TABLE_DEPTH);
      y    = (x * LN2_Q30) >> 30;
      term = Q30_ONE;
      sum  = Q30_ONE;
      for (int k = 1; k <= 12; k++) begin
        term = ((term * y) >> 30) / 64'(k);
        if (k % 2 == 1) begin
          sum = sum - term;
        end else begin
          sum = sum + term;
        end
      end
      ent          = (sum + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
      decay_tab[i] = ent[FW-1:0];
    end
  endtask

  // level * max * (2^DAC-1) / (10000 << FRAC), truncated then clamped
  function automatic logic [DAC_BITS-1:0] duty_of(input logic [LVL_W-1:0] level);
    logic [63:0] v;
    v = (64'(level) * 64'(cfg_max) * 64'(DMAX)) / (64'(PWM_DIV) << FRAC_BITS);
    if (v > 64'(DMAX)) begin
      v = 64'(DMAX);
    end
    return v[DAC_BITS-1:0];
  endfunction

  // One tick: move the levels, then form the result from them.
  function automatic lamp_out_t advance_levels(input logic [MS_W-1:0] ms);
    logic [31:0]      prod;
    logic [31:0]      whole;
    logic [31:0]      part;
    logic [31:0]      slot;
    logic [63:0]      f;
    logic [LVL_W-1:0] lv;
    lamp_out_t        o;
    if (cfg_mode == MODE_STATIC) begin
      lvl_left  = LVL_FULL;
      lvl_right = LVL_FULL;
    end else if (cfg_mode == MODE_BREATH || cfg_mode == MODE_OPPOSED) begin
      // whole half-lives become a shift, the remainder a table lookup
      prod  = 32'(ms) * 32'(cfg_speed);
      whole = prod / 32'(PERIOD_DIV);
      part  = prod % 32'(PERIOD_DIV);
      slot  = (part * 32'(EXP_TABLE_DEPTH)) / 32'(PERIOD_DIV);
      if (slot >= 32'(EXP_TABLE_DEPTH)) begin
        slot = 32'(EXP_TABLE_DEPTH - 1);
      end
      f  = (whole >= 32) ? 64'd0 : (64'(decay_tab[slot[IDX_W-1:0]]) >> whole);
      lv = (lvl_left > LVL_FULL) ? LVL_FULL : lvl_left;
      if (aim_high) begin
        lv = LVL_FULL - LVL_W'((64'(LVL_FULL - lv) * f) >> FRAC_BITS);
      end else begin
        lv = LVL_W'((64'(lv) * f) >> FRAC_BITS);
      end
      lvl_left = lv;
      // hysteresis: turn around near either end
      if (lv >= LVL_HI) begin
        aim_high = 1'b0;
      end
      if (lv <= LVL_LO) begin
        aim_high = 1'b1;
      end
      lvl_right = (cfg_mode == MODE_BREATH) ? lv : LVL_FULL - lv;
    end
    // unimplemented modes leave the levels where the mode write put them
    o.left_pwm  = duty_of(lvl_left);
    o.right_pwm = duty_of(lvl_right);
    o.left_pct  = lvl_left[FRAC_BITS +: PCT_W];
    o.right_pct = lvl_right[FRAC_BITS +: PCT_W];
    return o;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    err_count++;
    if (shown_count < 40) begin
      shown_count++;
      $display("MISMATCH %0s: got %0d, want %0d (result %0d)", what, got, want,
               results_seen);
    end
  endtask

  // --------------------------------------------------------------------------
  // Configuration: writes only while the core is idle; the shadow copy is
  // updated at once since nothing is in flight.
  // --------------------------------------------------------------------------
  task automatic wait_drained();
    do begin
      @(negedge clk_i);
    end while (tick_queue.size() != 0 || s_axis_tvalid_i || lamp_expect_q.size() != 0);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    case (idx)
      REG_MAX_LEVEL: begin
        cfg_max = val;
      end
      REG_EFFECT_MODE: begin
        // any mode write clears both levels, the target survives
        cfg_mode  = val[MODE_W-1:0];
        lvl_left  = '0;
        lvl_right = '0;
      end
      REG_SPEED: begin
        cfg_speed = val;
      end
      default: begin
      end
    endcase
  endtask

  task automatic end_writes();
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_all(input logic [MAX_W-1:0] mx, input logic [MODE_W-1:0] md,
                         input logic [SPD_W-1:0] sp);
    wait_drained();
    write_reg(REG_MAX_LEVEL, CFG_DATA_W'(mx));
    write_reg(REG_EFFECT_MODE, CFG_DATA_W'(md));
    write_reg(REG_SPEED, CFG_DATA_W'(sp));
    end_writes();
  endtask

  // Mostly short ticks so the levels actually breathe; some full-range ones.
  function automatic logic [MS_W-1:0] pick_ms();
    int r;
    r = $urandom_range(99);
    if (r < 10) begin
      return MS_W'($urandom_range(16'hFFFF));
    end else if (r < 13) begin
      return '0;
    end else if (r < 15) begin
      return '1;
    end
    return MS_W'($urandom_range(40000 / (int'(cfg_speed) + 1)));
  endfunction

  task automatic random_phase(input int count, input bit calm);
    int               r;
    logic [MAX_W-1:0] mx;
    logic [MODE_W-1:0] md;
    logic [SPD_W-1:0] sp;
    wait_drained();
    steady = calm;
    r  = $urandom_range(9);
    mx = (r < 2) ? MAX_W'(100) : (r < 3) ? '1 : (r < 4) ? '0 : MAX_W'($urandom_range(127));
    r  = $urandom_range(99);
    md = (r < 45) ? MODE_BREATH : (r < 80) ? MODE_OPPOSED : (r < 90) ? MODE_STATIC :
         MODE_W'($urandom_range(MODE_OPPOSED + 1, MODE_LAST));
    r  = $urandom_range(9);
    sp = (r == 0) ? '0 : (r == 1) ? SPD_W'(1) : (r == 2) ? '1 : (r == 3) ? SPD_W'(100) :
         SPD_W'($urandom_range(1, 100));
    write_reg(REG_MAX_LEVEL, CFG_DATA_W'(mx));
    // skipping the mode write now and then carries levels across phases
    if ($urandom_range(9) < 7) begin
      write_reg(REG_EFFECT_MODE, CFG_DATA_W'(md));
    end
    write_reg(REG_SPEED, CFG_DATA_W'(sp));
    end_writes();
    for (int i = 0; i < count; i++) begin
      tick_queue.push_back(pick_ms());
    end
  endtask

  // --------------------------------------------------------------------------
  // Request driver: holds each tick until taken, idles at random in between
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
      s_axis_tdata_i  <= '0;
    end else if (!s_axis_tvalid_i || s_axis_tready_o) begin
      if (tick_queue.size() != 0 && (steady || $urandom_range(99) >= 24)) begin
        s_axis_tvalid_i <= 1'b1;
        s_axis_tdata_i  <= IN_DATA_W'(tick_queue.pop_front());
      end else begin
        s_axis_tvalid_i <= 1'b0;
      end
    end
  end

  // Prediction at the edge where a request is taken.
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid_i && s_axis_tready_o) begin
      lamp_expect_q.push_back(advance_levels(s_axis_tdata_i[MS_W-1:0]));
    end
  end

  // --------------------------------------------------------------------------
  // Result monitor: checks in order; random ready, plus two long hold-offs
  // once the run is well under way
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    lamp_out_t got;
    lamp_out_t want;
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
      hold_left = 0;
    end else begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        got = lamp_out_t'(m_axis_tdata_o[OUT_FLD_W-1:0]);
        results_seen++;
        if (lamp_expect_q.size() == 0) begin
          report_mismatch("unexpected result", int'(got), 0);
        end else begin
          want = lamp_expect_q.pop_front();
          if (got.left_pwm != want.left_pwm) begin
            report_mismatch("left_pwm", int'(got.left_pwm), int'(want.left_pwm));
          end
          if (got.right_pwm != want.right_pwm) begin
            report_mismatch("right_pwm", int'(got.right_pwm), int'(want.right_pwm));
          end
          if (got.left_pct != want.left_pct) begin
            report_mismatch("left_percent", int'(got.left_pct), int'(want.left_pct));
          end
          if (got.right_pct != want.right_pct) begin
            report_mismatch("right_percent", int'(got.right_pct), int'(want.right_pct));
          end
        end
        if (results_seen == 200 || results_seen == 700) begin
          hold_left = HOLD_CYCLES;
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= steady || $urandom_range(99) >= 24;
      end
    end
  end

  // Watchdog: a hung core shows up as a long run with no handshake.
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid_i && s_axis_tready_o) ||
        (m_axis_tvalid_o && m_axis_tready_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus sequence
  // --------------------------------------------------------------------------
  initial begin
    err_count    = 0;
    shown_count  = 0;
    results_seen = 0;
    steady       = 1'b0;
    cfg_max      = '0;
    cfg_mode     = MODE_STATIC;
    cfg_speed    = SPD_W'(10);
    lvl_left     = '0;
    lvl_right    = '0;
    aim_high     = 1'b0;
    fill_decay_tab();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset values: static mode at zero brightness
    tick_queue.push_back('0);
    tick_queue.push_back('1);

    // breathing from zero: turn upward, half-life steps, saturate to full
    // (shift past 31), then collapse to zero
    set_all(MAX_W'(100), MODE_BREATH, SPD_W'(10));
    tick_queue.push_back('0);
    tick_queue.push_back(MS_W'(1500));
    tick_queue.push_back(MS_W'(1500));
    tick_queue.push_back('1);
    tick_queue.push_back(MS_W'(1));
    tick_queue.push_back('1);
    tick_queue.push_back(MS_W'(3000));

    // opposed, brightness above 100 saturates the PWM, top speed
    set_all('1, MODE_OPPOSED, '1);
    tick_queue.push_back(MS_W'(1));
    tick_queue.push_back(MS_W'(50));
    tick_queue.push_back('1);
    tick_queue.push_back(MS_W'(100));

    // zero speed freezes the levels; mode left alone so they are kept
    wait_drained();
    write_reg(REG_SPEED, '0);
    write_reg(REG_MAX_LEVEL, CFG_DATA_W'(1));
    end_writes();
    tick_queue.push_back('1);
    tick_queue.push_back(MS_W'(1000));

    // unimplemented modes give zero everywhere
    set_all(MAX_W'(100), MODE_W'(MODE_OPPOSED + 1), SPD_W'(100));
    tick_queue.push_back(MS_W'(500));
    set_all(MAX_W'(100), MODE_LAST, SPD_W'(1));
    tick_queue.push_back('1);

    // static at full brightness; a write to the unused index changes nothing
    set_all(MAX_W'(100), MODE_STATIC, SPD_W'(50));
    tick_queue.push_back(MS_W'(123));
    wait_drained();
    write_reg(REG_UNUSED, '1);
    end_writes();
    tick_queue.push_back(MS_W'(16'h5AA5));

    // random phases, one of them with no idling on either side
    for (int ph = 0; ph < 13; ph++) begin
      random_phase(85, ph == 6);
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
